>>> src/ri2cp_pkg.sv
package ri2cp_pkg;

   localparam int CORDIC_STAGES = 18;

   localparam int ROW_W   = 10;
   localparam int COL_W   = 12;
   localparam int RANGE_W = 24;
   localparam int POS_W   = 25;
   localparam int STEP_W  = 20;
   localparam int START_W = 26;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int PROD_W = COL_W + STEP_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int CS_W   = 32;
   localparam int ANG_W  = 25;

   localparam int TURN_Q16    = 360 * 65536;
   localparam int HALF_Q16    = TURN_Q16 / 2;
   localparam int QUARTER_Q16 = TURN_Q16 / 4;
   localparam int TURN_OFFSET = 2 * TURN_Q16;

   localparam int TURN_LOW_W  = 19;
   localparam int TURN_HIGH   = TURN_Q16 >> TURN_LOW_W;
   localparam int HIGH_W      = $clog2(TURN_HIGH);
   localparam int V_W         = SUM_W - TURN_LOW_W;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (2 ** RECIP_SHIFT + TURN_HIGH - 1) / TURN_HIGH;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int Q_W         = V_W + RECIP_W - RECIP_SHIFT;
   localparam int REM_W       = V_W + 2;
   localparam int M_W         = HIGH_W + TURN_LOW_W;

   localparam int SC_LATENCY = CORDIC_STAGES + 5;

   typedef enum logic [1:0] {
      REG_YAW_STEP,
      REG_PITCH_STEP,
      REG_YAW_START,
      REG_PITCH_START
   } csr_index_type;

   localparam int ATAN_DEG [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   function automatic longint unsigned cordic_gain(input int n);
      longint unsigned p;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned k2;
      longint unsigned one;
      int i;
      int k;
      one = 64'd1 << 30;
      p   = one;
      lo  = 64'd0;
      hi  = one;
      for (i = 0; i < n; i++) begin
         p = p + (p >> (2 * i));
      end
      for (k = 0; k < 30; k++) begin
         mid = (lo + hi) >> 1;
         k2  = (mid * mid) >> 30;
         if (((k2 * p) >> 30) <= one) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(cordic_gain(CORDIC_STAGES));

endpackage

>>> src/ri2cp_sincos.sv
module ri2cp_sincos
   import ri2cp_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic [PROD_W-1:0]         angle_prod,
   input  logic signed [START_W-1:0] angle_start,
   output logic signed [CS_W-1:0]    sin_out,
   output logic signed [CS_W-1:0]    cos_out
);

   logic signed [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]            sum_ff;

   logic [V_W+RECIP_W-1:0]      q_wide;
   logic [V_W-1:0]              v_ff;
   logic [Q_W-1:0]              q_ff;
   logic [TURN_LOW_W-1:0]       low_ff;

   logic signed [REM_W-1:0]     rem_raw;
   logic [HIGH_W-1:0]           rem_fix;
   logic [M_W-1:0]              m_ff;

   logic signed [M_W:0]         wrap_val;
   logic signed [ANG_W-1:0]     fold_val;
   logic                        fold_neg;

   logic signed [CS_W-1:0]      x_ff [0:CORDIC_STAGES];
   logic signed [CS_W-1:0]      y_ff [0:CORDIC_STAGES];
   logic signed [ANG_W-1:0]     z_ff [0:CORDIC_STAGES];
   logic                        neg_ff [0:CORDIC_STAGES];

   logic signed [CS_W-1:0]      sin_ff;
   logic signed [CS_W-1:0]      cos_ff;

   assign sum_wide = $signed({2'b00, angle_prod}) + (SUM_W+1)'(angle_start)
                     + (SUM_W+1)'(TURN_OFFSET);

   assign q_wide = (V_W+RECIP_W)'(sum_ff[SUM_W-1:TURN_LOW_W]) * (V_W+RECIP_W)'(RECIP);

   always_comb begin
      rem_raw = signed'(REM_W'(v_ff)) - signed'(REM_W'(q_ff) * REM_W'(TURN_HIGH));
      if (rem_raw < 0) begin
         rem_fix = HIGH_W'(rem_raw + REM_W'(TURN_HIGH));
      end else begin
         rem_fix = HIGH_W'(rem_raw);
      end
   end

   always_comb begin
      wrap_val = signed'({1'b0, m_ff});
      if (wrap_val >= (M_W+1)'(HALF_Q16)) begin
         wrap_val = wrap_val - (M_W+1)'(TURN_Q16);
      end
      if (wrap_val > (M_W+1)'(QUARTER_Q16)) begin
         fold_val = ANG_W'(wrap_val - (M_W+1)'(HALF_Q16));
         fold_neg = 1'b1;
      end else if (wrap_val < -(M_W+1)'(QUARTER_Q16)) begin
         fold_val = ANG_W'(wrap_val + (M_W+1)'(HALF_Q16));
         fold_neg = 1'b1;
      end else begin
         fold_val = ANG_W'(wrap_val);
         fold_neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff    <= sum_wide[SUM_W-1:0];
         v_ff      <= sum_ff[SUM_W-1:TURN_LOW_W];
         low_ff    <= sum_ff[TURN_LOW_W-1:0];
         q_ff      <= q_wide[V_W+RECIP_W-1:RECIP_SHIFT];
         m_ff      <= {rem_fix, low_ff};
         x_ff[0]   <= CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= fold_val;
         neg_ff[0] <= fold_neg;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (!z_ff[i][ANG_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ANG_W'(ATAN_DEG[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ANG_W'(ATAN_DEG[i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= neg_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
         cos_ff <= neg_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

>>> src/range_image_to_cartesian_points.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_row_index, req_col_index, req_range_value
// rsp      out        rsp_valid/rsp_ready   rsp_pos_x, rsp_pos_y, rsp_pos_z
// csr      in         csr_psel/csr_penable  csr_paddr, csr_pwdata, csr_prdata
//
// One transfer can be taken in every cycle unless the skid register is full; a result
// passes the two 18-stage CORDIC pipelines plus angle reduction and the product stages.
// Cells with a range of zero or below are dropped at the input and give no result.
// Reset clears all valid bits and the registers to their defaults.
// The output register and a skid register absorb a stalled result; the pipeline halts
// only while both are full.
module range_image_to_cartesian_points
   import ri2cp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ROW_W-1:0]             req_row_index,
   input  logic [COL_W-1:0]             req_col_index,
   input  logic signed [RANGE_W-1:0]    req_range_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [POS_W-1:0]      rsp_pos_x,
   output logic signed [POS_W-1:0]      rsp_pos_y,
   output logic signed [POS_W-1:0]      rsp_pos_z,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int MUL_W   = RANGE_W + CS_W;
   localparam int RC_W    = 33;
   localparam int WIDE_W  = RC_W + CS_W;
   localparam int OUT_MAX = 2 ** (POS_W - 1) - 1;
   localparam int OUT_MIN = -(2 ** (POS_W - 1));

   logic [STEP_W-1:0]          yaw_step_ff;
   logic [STEP_W-1:0]          pitch_step_ff;
   logic signed [START_W-1:0]  yaw_start_ff;
   logic signed [START_W-1:0]  pitch_start_ff;
   csr_index_type              csr_index;
   logic                       csr_write;

   logic                       en;
   logic                       accept;
   logic                       keep_in;

   logic [PROD_W-1:0]          yaw_prod_ff;
   logic [PROD_W-1:0]          pitch_prod_ff;
   logic [SC_LATENCY:0]        line_valid_ff;
   logic signed [RANGE_W-1:0]  range_line_ff [0:SC_LATENCY];

   logic signed [CS_W-1:0]     sin_yaw;
   logic signed [CS_W-1:0]     cos_yaw;
   logic signed [CS_W-1:0]     sin_pitch;
   logic signed [CS_W-1:0]     cos_pitch;

   logic                       p1_valid_ff;
   logic signed [MUL_W-1:0]    rc_prod_ff;
   logic signed [MUL_W-1:0]    zp_prod_ff;
   logic signed [CS_W-1:0]     p1_sy_ff;
   logic signed [CS_W-1:0]     p1_cy_ff;

   logic                       p2_valid_ff;
   logic signed [RC_W-1:0]     rc_ff;
   logic signed [POS_W-1:0]    p2_z_ff;
   logic signed [CS_W-1:0]     p2_sy_ff;
   logic signed [CS_W-1:0]     p2_cy_ff;

   logic                       p3_valid_ff;
   logic signed [WIDE_W-1:0]   x_prod_ff;
   logic signed [WIDE_W-1:0]   y_prod_ff;
   logic signed [POS_W-1:0]    p3_z_ff;

   logic signed [POS_W-1:0]    x_in;
   logic signed [POS_W-1:0]    y_in;

   logic                       out_valid_ff;
   logic signed [POS_W-1:0]    out_x_ff;
   logic signed [POS_W-1:0]    out_y_ff;
   logic signed [POS_W-1:0]    out_z_ff;
   logic                       skid_valid_ff;
   logic signed [POS_W-1:0]    skid_x_ff;
   logic signed [POS_W-1:0]    skid_y_ff;
   logic signed [POS_W-1:0]    skid_z_ff;

   function automatic logic signed [WIDE_W-1:0] round_shift(
      input logic signed [WIDE_W-1:0] v,
      input int                       s
   );
      logic signed [WIDE_W-1:0] half;
      half = WIDE_W'(64'd1 << (s - 1));
      if (!v[WIDE_W-1]) begin
         return (v + half) >>> s;
      end
      return -((-v + half) >>> s);
   endfunction

   function automatic logic signed [POS_W-1:0] saturate(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_W'(OUT_MAX)) begin
         return POS_W'(OUT_MAX);
      end
      if (v < WIDE_W'(OUT_MIN)) begin
         return POS_W'(OUT_MIN);
      end
      return POS_W'(v);
   endfunction

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_step_ff    <= STEP_W'(65536);
         pitch_step_ff  <= STEP_W'(65536);
         yaw_start_ff   <= '0;
         pitch_start_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_YAW_STEP:    yaw_step_ff    <= csr_pwdata[STEP_W-1:0];
            REG_PITCH_STEP:  pitch_step_ff  <= csr_pwdata[STEP_W-1:0];
            REG_YAW_START:   yaw_start_ff   <= signed'(csr_pwdata[START_W-1:0]);
            REG_PITCH_START: pitch_start_ff <= signed'(csr_pwdata[START_W-1:0]);
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_YAW_STEP:    csr_prdata = CSR_DATA_W'(yaw_step_ff);
         REG_PITCH_STEP:  csr_prdata = CSR_DATA_W'(pitch_step_ff);
         REG_YAW_START:   csr_prdata = CSR_DATA_W'(yaw_start_ff);
         REG_PITCH_START: csr_prdata = CSR_DATA_W'(pitch_start_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign en        = ~skid_valid_ff;
   assign req_ready = en;
   assign accept    = req_valid & req_ready;
   assign keep_in   = accept & ~req_range_value[RANGE_W-1] & (req_range_value != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         p3_valid_ff   <= 1'b0;
      end else if (en) begin
         line_valid_ff <= {line_valid_ff[SC_LATENCY-1:0], keep_in};
         p1_valid_ff   <= line_valid_ff[SC_LATENCY];
         p2_valid_ff   <= p1_valid_ff;
         p3_valid_ff   <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_prod_ff      <= PROD_W'(req_row_index) * PROD_W'(yaw_step_ff);
         pitch_prod_ff    <= PROD_W'(req_col_index) * PROD_W'(pitch_step_ff);
         range_line_ff[0] <= req_range_value;
         for (int k = 1; k <= SC_LATENCY; k++) begin
            range_line_ff[k] <= range_line_ff[k-1];
         end
      end
   end

   ri2cp_sincos u_yaw (
      .clock       (clock),
      .en          (en),
      .angle_prod  (yaw_prod_ff),
      .angle_start (yaw_start_ff),
      .sin_out     (sin_yaw),
      .cos_out     (cos_yaw)
   );

   ri2cp_sincos u_pitch (
      .clock       (clock),
      .en          (en),
      .angle_prod  (pitch_prod_ff),
      .angle_start (pitch_start_ff),
      .sin_out     (sin_pitch),
      .cos_out     (cos_pitch)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         rc_prod_ff <= MUL_W'(range_line_ff[SC_LATENCY]) * MUL_W'(cos_pitch);
         zp_prod_ff <= MUL_W'(range_line_ff[SC_LATENCY]) * MUL_W'(sin_pitch);
         p1_sy_ff   <= sin_yaw;
         p1_cy_ff   <= cos_yaw;

         rc_ff      <= RC_W'(round_shift(WIDE_W'(rc_prod_ff), 22));
         p2_z_ff    <= saturate(round_shift(WIDE_W'(zp_prod_ff), 30));
         p2_sy_ff   <= p1_sy_ff;
         p2_cy_ff   <= p1_cy_ff;

         x_prod_ff  <= WIDE_W'(rc_ff) * WIDE_W'(p2_cy_ff);
         y_prod_ff  <= WIDE_W'(rc_ff) * WIDE_W'(p2_sy_ff);
         p3_z_ff    <= p2_z_ff;
      end
   end

   assign x_in = saturate(round_shift(x_prod_ff, 38));
   assign y_in = saturate(round_shift(y_prod_ff, 38));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_valid_ff && !rsp_ready) begin
         skid_valid_ff <= p3_valid_ff;
      end else begin
         out_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
            out_z_ff <= skid_z_ff;
         end
      end else if (out_valid_ff && !rsp_ready) begin
         skid_x_ff <= x_in;
         skid_y_ff <= y_in;
         skid_z_ff <= p3_z_ff;
      end else begin
         out_x_ff <= x_in;
         out_y_ff <= y_in;
         out_z_ff <= p3_z_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pos_x = out_x_ff;
   assign rsp_pos_y = out_y_ff;
   assign rsp_pos_z = out_z_ff;

endmodule

>>> sim/tb_range_image_to_cartesian_points.sv
module tb_range_image_to_cartesian_points;
   import ri2cp_pkg::*;

   localparam longint FULL_TURN_Q16    = 360 * 65536;
   localparam longint HALF_TURN_Q16    = 180 * 65536;
   localparam longint QUARTER_TURN_Q16 = 90 * 65536;
   localparam longint POS_HIGH = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_LOW  = -(longint'(1) << (POS_W - 1));
   localparam int START_LIMIT = 23592960;
   localparam int PHASES = 6;
   localparam int POINTS_PER_PHASE = 155;
   localparam int DRAIN_CYCLES = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_N = 21;

   localparam longint ARCTAN_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic signed [RANGE_W-1:0] range_q8;
      logic                      no_point;
   } pixel_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ROW_W-1:0] req_row_index = '0;
   logic [COL_W-1:0] req_col_index = '0;
   logic signed [RANGE_W-1:0] req_range_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic signed [POS_W-1:0] rsp_pos_z;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic [STEP_W-1:0] yaw_step_q16 = 20'd65536;
   logic [STEP_W-1:0] pitch_step_q16 = 20'd65536;
   longint yaw_start_q16 = 0;
   longint pitch_start_q16 = 0;
   longint gain_q30;

   point_type points_pending [$];
   int mismatches = 0;
   bit calm_tail = 1'b0;

   pixel_type directed_pixels [DIRECTED_N] = '{
      '{10'd0, 12'd0, 24'sd1, 1'b0},
      '{10'd0, 12'd0, 24'sh7FFFFF, 1'b0},
      '{10'd1023, 12'd4095, 24'sh7FFFFF, 1'b0},
      '{10'd0, 12'd0, 24'sd0, 1'b1},
      '{10'd5, 12'd7, -24'sd1, 1'b1},
      '{10'd1023, 12'd4095, 24'sh800000, 1'b1},
      '{10'd90, 12'd0, 24'sd256, 1'b0},
      '{10'd0, 12'd90, 24'sd256, 1'b0},
      '{10'd91, 12'd91, 24'sd25600, 1'b0},
      '{10'd89, 12'd89, 24'sd25600, 1'b0},
      '{10'd180, 12'd180, 24'sd65536, 1'b0},
      '{10'd181, 12'd179, 24'sd65536, 1'b0},
      '{10'd270, 12'd270, 24'sd100000, 1'b0},
      '{10'd359, 12'd359, 24'sd100000, 1'b0},
      '{10'd360, 12'd720, 24'sd3000000, 1'b0},
      '{10'd45, 12'd30, 24'sd12345, 1'b0},
      '{10'd1023, 12'd0, 24'sd777777, 1'b0},
      '{10'd0, 12'd4095, 24'sd777777, 1'b0},
      '{10'd512, 12'd2048, 24'sh555555, 1'b0},
      '{10'd341, 12'd1365, 24'sh2AAAAA, 1'b0},
      '{10'd682, 12'd2730, 24'sh400000, 1'b0}
   };

   range_image_to_cartesian_points dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_row_index(req_row_index),
      .req_col_index(req_col_index),
      .req_range_value(req_range_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic longint unsigned unit_gain_q30(input int stages);
      longint unsigned prod;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned sq;
      prod = 64'd1 << 30;
      lo = 64'd0;
      hi = 64'd1 << 30;
      for (int i = 0; i < stages; i++) begin
         prod = prod + (prod >> (2 * i));
      end
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         sq = (mid * mid) >> 30;
         if (((sq * prod) >> 30) <= (64'd1 << 30)) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) begin
         return (v + half) >>> s;
      end
      return -((-v + half) >>> s);
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_q8(input longint v);
      if (v > POS_HIGH) begin
         v = POS_HIGH;
      end
      if (v < POS_LOW) begin
         v = POS_LOW;
      end
      return v[POS_W-1:0];
   endfunction

   // The angle is wrapped into [-180, 180) and folded into [-90, 90], with the
   // sign of both outputs flipped when folding was needed.
   function automatic void angle_sin_cos(input longint angle, output longint sine,
                                         output longint cosine);
      longint m;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit flip;
      flip = 1'b0;
      m = angle % FULL_TURN_Q16;
      if (m < 0) begin
         m = m + FULL_TURN_Q16;
      end
      if (m >= HALF_TURN_Q16) begin
         m = m - FULL_TURN_Q16;
      end
      if (m > QUARTER_TURN_Q16) begin
         m = m - HALF_TURN_Q16;
         flip = 1'b1;
      end else if (m < -QUARTER_TURN_Q16) begin
         m = m + HALF_TURN_Q16;
         flip = 1'b1;
      end
      x = gain_q30;
      y = 0;
      z = m;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_Q16[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_Q16[i];
         end
      end
      sine = flip ? -y : y;
      cosine = flip ? -x : x;
   endfunction

   function automatic bit pixel_to_point(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col,
                                         input logic signed [RANGE_W-1:0] range_q8,
                                         output point_type pt);
      longint r;
      longint sy;
      longint cy;
      longint sp;
      longint cp;
      longint rc;
      pt = '0;
      r = range_q8;
      if (r <= 0) begin
         return 1'b0;
      end
      angle_sin_cos(yaw_start_q16 + longint'(row) * longint'(yaw_step_q16), sy, cy);
      angle_sin_cos(pitch_start_q16 + longint'(col) * longint'(pitch_step_q16), sp, cp);
      rc = round_shift(r * cp, 22);
      pt.x = clamp_q8(round_shift(rc * cy, 38));
      pt.y = clamp_q8(round_shift(rc * sy, 38));
      pt.z = clamp_q8(round_shift(r * sp, 30));
      return 1'b1;
   endfunction

   function automatic void check_coord(input string name, input logic signed [POS_W-1:0] want,
                                       input logic signed [POS_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function automatic int random_start();
      return int'($urandom_range(0, 2 * START_LIMIT)) - START_LIMIT;
   endfunction

   task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic signed [RANGE_W-1:0] range_q8, input bit no_point);
      point_type pt;
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_index <= row;
      req_col_index <= col;
      req_range_value <= range_q8;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (!no_point && pixel_to_point(row, col, range_q8, pt)) begin
         points_pending = {points_pending, pt};
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (points_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_YAW_STEP: begin
            yaw_step_q16 = value[STEP_W-1:0];
         end
         REG_PITCH_STEP: begin
            pitch_step_q16 = value[STEP_W-1:0];
         end
         REG_YAW_START: begin
            yaw_start_q16 = longint'($signed(value[START_W-1:0]));
         end
         REG_PITCH_START: begin
            pitch_start_q16 = longint'($signed(value[START_W-1:0]));
         end
         default: begin
         end
      endcase
   endtask

   task automatic apply_setting(input logic [STEP_W-1:0] yaw_step,
                                input logic [STEP_W-1:0] pitch_step,
                                input int yaw_start, input int pitch_start);
      write_csr(REG_YAW_STEP, CSR_DATA_W'(yaw_step));
      write_csr(REG_PITCH_STEP, CSR_DATA_W'(pitch_step));
      write_csr(REG_YAW_START, CSR_DATA_W'(yaw_start));
      write_csr(REG_PITCH_START, CSR_DATA_W'(pitch_start));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int n;
      forever begin
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         repeat (n) @(posedge clock);
         if (!calm_tail && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (points_pending.size() == 0) begin
            mismatches++;
            $display("%0t: expected no point, got x=%0d y=%0d z=%0d", $time,
                     rsp_pos_x, rsp_pos_y, rsp_pos_z);
         end else begin
            want = points_pending.pop_front();
            check_coord("pos_x", want.x, rsp_pos_x);
            check_coord("pos_y", want.y, rsp_pos_y);
            check_coord("pos_z", want.z, rsp_pos_z);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles, expected %0d more points", $time,
               WATCHDOG_LIMIT, points_pending.size());
      $display("range_image_to_cartesian_points: mismatch");
      $finish;
   end

   initial begin
      int p;
      int sent;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic signed [RANGE_W-1:0] range_q8;
      gain_q30 = longint'(unit_gain_q30(CORDIC_STAGES));
      while (reset) @(posedge clock);

      for (int i = 0; i < DIRECTED_N; i++) begin
         send_pixel(directed_pixels[i].row, directed_pixels[i].col,
                    directed_pixels[i].range_q8, directed_pixels[i].no_point);
      end

      for (p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: apply_setting(20'd1, 20'd1, -START_LIMIT, -START_LIMIT);
            1: apply_setting(20'hFFFFF, 20'hFFFFF, START_LIMIT, START_LIMIT);
            2: apply_setting(20'd23040, 20'd5760, -11796480, -1048576);
            3: apply_setting(20'd0, 20'd0, random_start(), random_start());
            default: apply_setting(STEP_W'($urandom_range(1, 20'hFFFFF)),
                                   STEP_W'($urandom_range(1, 20'hFFFFF)),
                                   random_start(), random_start());
         endcase
         calm_tail = (p == PHASES - 1);
         sent = 0;
         while (sent < POINTS_PER_PHASE) begin
            row = ROW_W'($urandom_range(0, 1023));
            col = COL_W'($urandom_range(0, 4095));
            case ($urandom_range(0, 15)) inside
               0: range_q8 = '0;
               1, 2: range_q8 = {1'b1, 23'($urandom)};
               3: range_q8 = ($urandom_range(0, 1) == 0) ? 24'sh7FFFFF : 24'sd1;
               4, 5, 6: range_q8 = RANGE_W'($urandom_range(1, 4095));
               default: range_q8 = RANGE_W'($urandom_range(1, 24'h7FFFFF));
            endcase
            send_pixel(row, col, range_q8, 1'b0);
            sent++;
         end
      end
      settle();

      if (mismatches == 0) begin
         $display("range_image_to_cartesian_points: match");
      end else begin
         $display("range_image_to_cartesian_points: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ri2cp_pkg.sv
src/ri2cp_sincos.sv
src/range_image_to_cartesian_points.sv
sim/tb_range_image_to_cartesian_points.sv
